// File: sv/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types, codes and defaults for the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

    // Default sizing of the allocator.
    localparam int NUM_CPUS_DEF   = 8;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAX_PAGES_DEF  = 1024;

    // Fixed field widths of the request and result items.
    localparam int ADDR_W   = 32;
    localparam int CPUID_W  = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // Stream bus widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP   = 1'b1;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] REGION_TOP_RST   = 32'h0040_0000;

    // Request kind.
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC = 2'd0,
        ST_FREED = 2'd1,
        ST_NONE  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request and start the link read
        logic commit;  // update the lists and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;  // result register holds an untaken result
    } t_stat;

    // Reduce a CPU number modulo the CPU count by repeated subtraction.
    function automatic logic [CPUID_W-1:0] cpu_wrap(input logic [CPUID_W-1:0] id,
                                                    input int unsigned n);
        logic [CPUID_W:0] v;
        v = {1'b0, id};
        for (int k = 0; k < (1 << CPUID_W); k++) begin
            if (32'(v) >= n) begin
                v = v - (CPUID_W+1)'(n);
            end
        end
        return v[CPUID_W-1:0];
    endfunction

endpackage

// File: sv/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/pcpa_ctrl.sv
// ----------------------------------------------------------------------------
// pcpa_ctrl
// Controller for the allocator: takes a request, then commits it once the
// result register is free.
// ----------------------------------------------------------------------------
module pcpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  logic           i_res_ready,
    input  pcpa_pkg::t_stat i_stat,
    output pcpa_pkg::t_cmd  o_cmd
);
    import pcpa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result register must be empty or emptying this cycle.
                if (!i_stat.out_valid || i_res_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/pcpa_datapath.sv
// ----------------------------------------------------------------------------
// pcpa_datapath
// List heads, non-empty flags, the shared next-link RAM, address checks and
// the result register of the allocator.
// ----------------------------------------------------------------------------
module pcpa_datapath #(
    parameter int NUM_CPUS   = pcpa_pkg::NUM_CPUS_DEF,
    parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcpa_pkg::t_cmd                    i_cmd,
    output pcpa_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcpa_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                              i_in_op,
    input  logic [pcpa_pkg::CPUID_W-1:0]      i_in_cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]       i_in_addr,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [pcpa_pkg::ADDR_W-1:0]       o_out_addr,
    output logic [pcpa_pkg::STATUS_W-1:0]     o_out_status,
    output logic                              o_out_stolen
);
    import pcpa_pkg::*;

    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PW = $clog2(MAX_PAGES);
    localparam int LW = PW + 1;
    localparam int OB = $clog2(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] MAX_PAGES_W = ADDR_W'(MAX_PAGES);

    // Configuration registers.
    logic [ADDR_W-1:0] r_region_start;
    logic [ADDR_W-1:0] r_region_top;

    // List state.
    logic [PW-1:0]       r_head [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_nonempty;

    // Captured request.
    t_op               r_op;
    logic [CW-1:0]     r_cpu;
    logic [ADDR_W-1:0] r_addr;
    logic [CW-1:0]     r_src;
    logic              r_found;
    logic              r_stolen;

    // Result register.
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;
    logic              r_out_stolen;

    // Request-cycle signals.
    logic [CW-1:0] in_cpu;
    logic [CW-1:0] low_src;
    logic [CW-1:0] src_sel;
    logic          own_nonempty;
    logic          any_nonempty;

    // Commit-cycle signals.
    logic [PW-1:0]     free_idx;
    logic              bad_free;
    logic [LW-1:0]     push_link;
    logic [PW-1:0]     pop_idx;
    logic [LW-1:0]     pop_link;
    logic [PW-1:0]     pop_next;
    logic              do_push;
    logic              do_pop;

    // Source list selection: own list first, else the lowest non-empty one.
    always_comb begin
        in_cpu       = CW'(cpu_wrap(i_in_cpu, NUM_CPUS));
        own_nonempty = r_nonempty[in_cpu];
        any_nonempty = |r_nonempty;
        low_src      = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                low_src = CW'(i);
            end
        end
        src_sel = own_nonempty ? in_cpu : low_src;
    end

    // Free address checks and link arithmetic.
    always_comb begin
        free_idx  = r_addr[OB +: PW];
        bad_free  = (r_addr[OB-1:0] != '0) || (r_addr < r_region_start) ||
                    (r_addr >= r_region_top) || ((r_addr >> OB) >= MAX_PAGES_W);
        push_link = r_nonempty[r_cpu] ? (LW'(r_head[r_cpu]) + LW'(1)) : '0;
        pop_idx   = r_head[r_src];
        pop_next  = PW'(pop_link - LW'(1));
        do_push   = i_cmd.commit && (r_op == OP_FREE) && !bad_free;
        do_pop    = i_cmd.commit && (r_op == OP_ALLOC) && r_found;
    end

    // Shared next-link table.
    pcpa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (free_idx),
        .i_wdata (push_link),
        .i_re    (i_cmd.load && (t_op'(i_in_op) == OP_ALLOC)),
        .i_raddr (r_head[src_sel]),
        .o_rdata (pop_link)
    );

    // Configuration, list state and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= REGION_START_RST;
            r_region_top   <= REGION_TOP_RST;
            r_nonempty     <= '0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_head[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_REGION_START) begin
                    r_region_start <= i_cfg_data;
                end else if (i_cfg_idx == REG_REGION_TOP) begin
                    r_region_top <= i_cfg_data;
                end
            end
            if (do_push) begin
                r_head[r_cpu]     <= free_idx;
                r_nonempty[r_cpu] <= 1'b1;
            end
            if (do_pop) begin
                if (pop_link == '0) begin
                    r_nonempty[r_src] <= 1'b0;
                    r_head[r_src]     <= '0;
                end else begin
                    r_head[r_src] <= pop_next;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_in_op);
            r_cpu    <= in_cpu;
            r_addr   <= i_in_addr;
            r_src    <= src_sel;
            r_found  <= any_nonempty;
            r_stolen <= !own_nonempty && any_nonempty;
        end
        if (i_cmd.commit) begin
            r_out_addr   <= '0;
            r_out_stolen <= 1'b0;
            if (r_op == OP_FREE) begin
                r_out_status <= bad_free ? ST_BAD : ST_FREED;
            end else if (r_found) begin
                r_out_addr   <= ADDR_W'(pop_idx) << OB;
                r_out_status <= ST_ALLOC;
                r_out_stolen <= r_stolen;
            end else begin
                r_out_status <= ST_NONE;
            end
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_out_addr       = r_out_addr;
    assign o_out_status     = r_out_status;
    assign o_out_stolen     = r_out_stolen;

endmodule

// File: sv/per_cpu_page_free_list_allocator.sv
// Sequencing: a taken request moves the controller to its execute state, and its
// result is registered once the result register is empty or being emptied.
// No request is taken until the previous one commits; an allocate reads the popped
// page's next link from the registered-read link RAM before the head updates.
// A new request is taken while an earlier result still waits on the output.
// Reset: all lists empty, region registers back to their defaults; the link
// RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Page allocator with one LIFO free list per CPU and stealing from the
// lowest-numbered non-empty list when the caller's own list is empty.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator #(
    parameter int NUM_CPUS   = pcpa_pkg::NUM_CPUS_DEF,
    parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pcpa_pkg::ADDR_W-1:0]      i_cfg_data,
    // Request stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pcpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // cpu_id[2:0], page_addr[34:3]
    input  logic                             s_axis_tuser,  // operation[0]
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pcpa_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // alloc_addr[31:0]
    output logic [pcpa_pkg::M_TUSER_W-1:0]   m_axis_tuser   // status[1:0], stolen[2]
);
    import pcpa_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [STATUS_W-1:0] out_status;
    logic                out_stolen;

    // Sequencing of each request.
    pcpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_res_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Lists, link table and result register.
    pcpa_datapath #(
        .NUM_CPUS   (NUM_CPUS),
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_op      (s_axis_tuser),
        .i_in_cpu     (s_axis_tdata[CPUID_W-1:0]),
        .i_in_addr    (s_axis_tdata[CPUID_W +: ADDR_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_addr   (m_axis_tdata),
        .o_out_status (out_status),
        .o_out_stolen (out_stolen)
    );

    // Result sideband packing.
    assign m_axis_tuser = {out_stolen, out_status};

endmodule
